// ----- rtl/srs_pkg.sv -----
// Shared types and constants of the stable record sorter.
package srs_pkg;

  localparam int unsigned KeyW        = 16;
  localparam int unsigned TagW        = 8;
  localparam int unsigned CapacityDef = 16;

  // One stored record: sort key in the upper bits, tag in the lower bits.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } record_t;

  // Request from the sequencer to the output register.
  typedef struct packed {
    logic load;
    logic last;
  } emit_ctl_t;

endpackage

// ----- rtl/srs_mem.sv -----
// Record memory: one write port and one read port with registered read data.
module srs_mem import srs_pkg::*; #(
  parameter int unsigned Depth = CapacityDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  record_t          wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output record_t          rdata_o
);

  record_t mem [Depth];
  record_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/srs_ctrl.sv -----
// Sequencer of the sorter: loading, bubble passes over the memory and readout.
module srs_ctrl import srs_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned AddrW    = $clog2(Capacity),
  parameter int unsigned FillW    = $clog2(Capacity + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TagW-1:0]  tag_i,
  input  logic [KeyW-1:0]  sort_key_i,
  input  logic             final_item_i,
  input  logic             out_free_i,
  output emit_ctl_t        emit_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output record_t          mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  record_t          mem_rdata_i
);

  localparam logic [2:0] StLoad   = 3'd0;
  localparam logic [2:0] StSort   = 3'd1;
  localparam logic [2:0] StDrain  = 3'd2;
  localparam logic [2:0] StFlush  = 3'd3;
  localparam logic [2:0] StEmitWt = 3'd4;
  localparam logic [2:0] StEmitRd = 3'd5;
  localparam logic [2:0] StEmitLd = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [AddrW-1:0] end_q, end_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic             prv_vld_q, prv_vld_d;
  logic [AddrW-1:0] prv_addr_q, prv_addr_d;
  logic [AddrW-1:0] emit_q, emit_d;
  logic [AddrW-1:0] cnt_last_q, cnt_last_d;
  record_t          carry_q, carry_d;

  logic             room;
  logic [FillW-1:0] new_cnt;
  logic [FillW-1:0] cnt_m1;

  assign room    = (fill_q != FillW'(Capacity));
  assign new_cnt = room ? (fill_q + FillW'(1)) : fill_q;
  assign cnt_m1  = new_cnt - FillW'(1);

  assign in_ready_o = (state_q == StLoad);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    end_d       = end_q;
    pos_d       = pos_q;
    prv_vld_d   = 1'b0;
    prv_addr_d  = prv_addr_q;
    emit_d      = emit_q;
    cnt_last_d  = cnt_last_q;
    carry_d     = carry_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = carry_q;
    mem_raddr_o = pos_q;
    emit_o      = '0;

    // Compare the record read last cycle against the carried one; the record from address zero becomes the carry.
    if (prv_vld_q) begin
      if (prv_addr_q == '0) begin
        carry_d = mem_rdata_i;
      end else begin
        mem_we_o    = 1'b1;
        mem_waddr_o = prv_addr_q - AddrW'(1);
        if (carry_q.key > mem_rdata_i.key) begin
          mem_wdata_o = mem_rdata_i;
        end else begin
          mem_wdata_o = carry_q;
          carry_d     = mem_rdata_i;
        end
      end
    end

    case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          if (room) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = fill_q[AddrW-1:0];
            mem_wdata_o = '{key: sort_key_i, tag: tag_i};
          end
          fill_d = new_cnt;
          if (final_item_i) begin
            fill_d     = '0;
            cnt_last_d = cnt_m1[AddrW-1:0];
            end_d      = cnt_m1[AddrW-1:0];
            pos_d      = '0;
            emit_d     = '0;
            state_d    = (new_cnt == FillW'(1)) ? StEmitWt : StSort;
          end
        end
      end
      StSort: begin
        mem_raddr_o = pos_q;
        prv_vld_d   = 1'b1;
        prv_addr_d  = pos_q;
        if (pos_q == end_q) begin
          state_d = StDrain;
        end else begin
          pos_d = pos_q + AddrW'(1);
        end
      end
      StDrain: begin
        state_d = StFlush;
      end
      StFlush: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = end_q;
        mem_wdata_o = carry_q;
        pos_d       = '0;
        if (end_q == AddrW'(1)) begin
          state_d = StEmitWt;
        end else begin
          end_d   = end_q - AddrW'(1);
          state_d = StSort;
        end
      end
      StEmitWt: begin
        if (out_free_i) begin
          state_d = StEmitRd;
        end
      end
      StEmitRd: begin
        mem_raddr_o = emit_q;
        state_d     = StEmitLd;
      end
      StEmitLd: begin
        emit_o.load = 1'b1;
        emit_o.last = (emit_q == cnt_last_q);
        if (emit_q == cnt_last_q) begin
          state_d = StLoad;
        end else begin
          emit_d  = emit_q + AddrW'(1);
          state_d = StEmitWt;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      fill_q    <= '0;
      prv_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      prv_vld_q <= prv_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q      <= end_d;
    pos_q      <= pos_d;
    prv_addr_q <= prv_addr_d;
    emit_q     <= emit_d;
    cnt_last_q <= cnt_last_d;
    carry_q    <= carry_d;
  end

endmodule

// ----- rtl/stable_record_sorter.sv -----
// Top level of the stable record sorter: memory, sequencer and output register.
//
// The block collects records (an 8-bit tag and a 16-bit unsigned key), one per
// accepted request, into a record memory of CAPACITY entries; records that
// arrive when the memory is full are dropped. The request marked final_item
// closes the set: the records are sorted into ascending key order, with equal
// keys kept in their load order, and then sent out one per output request,
// the last one flagged by end_of_run_o. While loading, the input stays ready
// for every request. The sort runs bubble passes, each of which streams its
// span of the memory through a single comparator with one read and one write
// per cycle, then drains the comparator and writes back the carried record.
// Readout waits until the output register is free or being taken, reads the
// record from the memory and loads it into the output register, one record
// at a time. The input side is closed from the final request until the last
// sorted record sits in the output register; that record may still wait
// there while the next set is being loaded.
module stable_record_sorter import srs_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [TagW-1:0] tag_i,
  input  logic [KeyW-1:0] sort_key_i,
  input  logic            final_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [TagW-1:0] out_tag_o,
  output logic [KeyW-1:0] out_key_o,
  output logic            end_of_run_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned FillW = $clog2(CAPACITY + 1);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  record_t          mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  record_t          mem_rdata;
  emit_ctl_t        emit;

  logic             out_valid_q, out_valid_d;
  record_t          out_rec_q, out_rec_d;
  logic             out_end_q, out_end_d;

  srs_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  srs_ctrl #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .FillW    (FillW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tag_i        (tag_i),
    .sort_key_i   (sort_key_i),
    .final_item_i (final_item_i),
    .out_free_i   (!out_valid_q || out_ready_i),
    .emit_o       (emit),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // The sequencer only loads the output register after it has seen it free,
  // so a load never overwrites a record that has not been taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_rec_d   = out_rec_q;
    out_end_d   = out_end_q;
    if (emit.load) begin
      out_valid_d = 1'b1;
      out_rec_d   = mem_rdata;
      out_end_d   = emit.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rec_q <= out_rec_d;
    out_end_q <= out_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_tag_o    = out_rec_q.tag;
  assign out_key_o    = out_rec_q.key;
  assign end_of_run_o = out_end_q;

endmodule

// ----- rtl/srs_checker.sv -----
// Port-level checks of the stable record sorter and their binding to it.
module srs_checker import srs_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            final_item_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [TagW-1:0] out_tag_o,
  input logic [KeyW-1:0] out_key_o,
  input logic            end_of_run_o
);

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_tag_o) &&
      $stable(out_key_o) && $stable(end_of_run_o))
    else $error("output record changed while stalled");

  // The final request closes the input side for the sort.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && final_item_i |=> !in_ready_o)
    else $error("input accepted right after the final request");

  // A record that is not final never starts a readout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !final_item_i |=> !$rose(out_valid_o))
    else $error("result appeared after a non-final request");

  // Only the last record of a run may appear while loading is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !end_of_run_o |-> !in_ready_o)
    else $error("input open while a run is still being emitted");

endmodule

bind stable_record_sorter srs_checker u_srs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .final_item_i (final_item_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_tag_o    (out_tag_o),
  .out_key_o    (out_key_o),
  .end_of_run_o (end_of_run_o)
);
